// ----- hdl/heater_pid_duty_top_macros.svh -----
// ---------------------------------------------------------------------------
// heater_pid_duty_top_macros.svh
// Assertion helpers for the heater PID duty block.
// ---------------------------------------------------------------------------
`ifndef HEATER_PID_DUTY_TOP_MACROS_SVH
`define HEATER_PID_DUTY_TOP_MACROS_SVH

// Plain invariant, checked on every clock edge outside reset
`define HPD_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Same-cycle implication
`define HPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hdl/hpd_pkg.sv -----
// ---------------------------------------------------------------------------
// hpd_pkg
// Shared constants and types for the heater PID duty block.
// ---------------------------------------------------------------------------
package hpd_pkg;

    // Field widths
    localparam int MeasW  = 15;
    localparam int SpW    = 10;
    localparam int DutyW  = 15;
    localparam int ErrW   = 17;
    localparam int IntegW = 13;

    // Internal arithmetic widths
    localparam int AccW = 24;  // integral + 125*e
    localparam int P1W  = 26;  // 775*e
    localparam int P2W  = 25;  // 375*previous error
    localparam int SumW = 27;  // full sum in half units

    // Gains (sum formed in half units)
    localparam int KiGain = 125;
    localparam int KpHalf = 1150;
    localparam int KdHalf = 375;
    localparam int ILimit = 4000;

    // Register map
    localparam int AddrW = 3;
    localparam logic RegSetpoint = 1'b0;

    // Error stage payload
    typedef struct packed {
        logic signed [ErrW-1:0]   err;
        logic signed [ErrW-1:0]   prev;
        logic signed [IntegW-1:0] integ;
    } t_err_item;

endpackage

// ----- hdl/hpd_integ.sv -----
// ---------------------------------------------------------------------------
// hpd_integ
// Error stage: forms the error, updates the clamped integral and the stored
// previous error, and registers all three for the sum stage.
// ---------------------------------------------------------------------------
module hpd_integ (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [hpd_pkg::SpW-1:0]  i_setpoint,
    input  logic                     i_a_vld,
    input  logic [hpd_pkg::MeasW-1:0] i_a_meas,
    input  logic                     i_a_stby,
    input  logic                     i_c_adv,
    output logic                     o_b_adv,
    output logic                     o_b_vld,
    output hpd_pkg::t_err_item       o_b_item
);
    import hpd_pkg::*;

    logic                     r_b_vld;
    t_err_item                r_b_item;
    logic signed [IntegW-1:0] r_integ;
    logic signed [ErrW-1:0]   r_prev;
    logic signed [IntegW-1:0] n_integ;

    logic [MeasW-1:0]         tgt;
    logic signed [ErrW-1:0]   err;
    logic signed [AccW-1:0]   acc;
    logic                     load;

    // Target in 1/16 degree, halved setpoint in standby
    always_comb begin
        if (i_a_stby) begin
            tgt = {2'b00, i_setpoint[SpW-1:1], 4'b0000};
        end else begin
            tgt = {1'b0, i_setpoint, 4'b0000};
        end
    end

    assign err = $signed({2'b00, tgt}) - $signed({{(ErrW-MeasW){i_a_meas[MeasW-1]}}, i_a_meas});

    // Integral update with saturation
    always_comb begin
        acc = AccW'(r_integ) + AccW'(err) * AccW'(KiGain);
        if (acc > AccW'(ILimit)) begin
            n_integ = IntegW'(ILimit);
        end else if (acc < -AccW'(ILimit)) begin
            n_integ = -IntegW'(ILimit);
        end else begin
            n_integ = acc[IntegW-1:0];
        end
    end

    assign o_b_adv = !r_b_vld || i_c_adv;
    assign load    = o_b_adv && i_a_vld;

    // Loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (load) begin
            r_integ <= n_integ;
            r_prev  <= err;
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (o_b_adv) begin
            r_b_vld <= i_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_b_item.err   <= err;
            r_b_item.prev  <= r_prev;
            r_b_item.integ <= n_integ;
        end
    end

    assign o_b_vld  = r_b_vld;
    assign o_b_item = r_b_item;

endmodule

// ----- hdl/hpd_sum.sv -----
// ---------------------------------------------------------------------------
// hpd_sum
// Sum stage: gain products, then the full sum, halving and saturation into
// the output register.
// ---------------------------------------------------------------------------
module hpd_sum #(
    parameter int DUTY_MAX = 24999
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_b_vld,
    input  hpd_pkg::t_err_item          i_b_item,
    input  logic                        i_out_stall,
    output logic                        o_c_adv,
    output logic                        o_out_valid,
    output logic [hpd_pkg::DutyW-1:0]   o_heater_duty
);
    import hpd_pkg::*;

    localparam logic [SumW-2:0] DutyMaxW = (SumW-1)'(DUTY_MAX);

    logic                     r_c_vld;
    logic signed [P1W-1:0]    r_c_p1;
    logic signed [P2W-1:0]    r_c_p2;
    logic signed [IntegW-1:0] r_c_integ;
    logic                     r_out_vld;
    logic [DutyW-1:0]         r_out_duty;

    logic                     out_adv;
    logic signed [SumW-1:0]   sum2;
    logic [SumW-2:0]          half;
    logic [SumW-2:0]          duty;

    assign out_adv = !r_out_vld || !i_out_stall;
    assign o_c_adv = !r_c_vld || out_adv;

    // Product stage: (Kp - Kd) on e, Kd on previous error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (o_c_adv) begin
            r_c_vld <= i_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_c_adv && i_b_vld) begin
            r_c_p1    <= P1W'(i_b_item.err) * P1W'(KpHalf - KdHalf);
            r_c_p2    <= P2W'(i_b_item.prev) * P2W'(KdHalf);
            r_c_integ <= i_b_item.integ;
        end
    end

    // Sum in half units, negative gives zero, then clamp to the top
    always_comb begin
        sum2 = SumW'(r_c_p1) + SumW'(r_c_p2) + (SumW'(r_c_integ) <<< 1);
        half = sum2[SumW-1:1];
        if (sum2[SumW-1]) begin
            duty = '0;
        end else if (half > DutyMaxW) begin
            duty = DutyMaxW;
        end else begin
            duty = half;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_c_vld) begin
            r_out_duty <= duty[DutyW-1:0];
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_heater_duty = r_out_duty;

endmodule

// ----- hdl/heater_pid_duty_top.sv -----
// ---------------------------------------------------------------------------
// heater_pid_duty_top
// PID heater regulator with clamped integral, one duty request per sample.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  input    | in        | i_in_valid / o_in_stall    | i_measured_temp, i_standby_mode
//  output   | out       | o_out_valid / i_out_stall  | o_heater_duty
//  config   | in        | APB psel/penable/pwrite    | setpoint_degrees at 0x0
//
//  Four register stages (input, error/integral, products, output): a request
//  passes through them in that order; while the output is not stalled, a new
//  one is taken every cycle.
//  The integral and previous error update in the error stage, so back to
//  back requests chain through the loop state registered in that stage.
//  Synchronous active-low reset clears the setpoint, loop state and valids.
//  A stall on the output only backs up the input once every stage is full.
// ---------------------------------------------------------------------------
`include "heater_pid_duty_top_macros.svh"

module heater_pid_duty_top #(
    parameter int DUTY_MAX = 24999
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [hpd_pkg::MeasW-1:0]    i_measured_temp,
    input  logic                         i_standby_mode,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [hpd_pkg::DutyW-1:0]    o_heater_duty,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hpd_pkg::AddrW-1:0]    paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import hpd_pkg::*;

    logic [SpW-1:0]   r_setpoint;
    logic             r_a_vld;
    logic [MeasW-1:0] r_a_meas;
    logic             r_a_stby;

    logic             a_adv;
    logic             b_adv;
    logic             c_adv;
    logic             b_vld;
    t_err_item        b_item;
    logic             reg_sel;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[AddrW-1] == RegSetpoint);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_setpoint <= pwdata[SpW-1:0];
        end
    end

    always_comb begin
        if (reg_sel) begin
            prdata = {{(32-SpW){1'b0}}, r_setpoint};
        end else begin
            prdata = '0;
        end
    end

    // Input register
    assign a_adv      = !r_a_vld || b_adv;
    assign o_in_stall = !a_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_adv) begin
            r_a_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && i_in_valid) begin
            r_a_meas <= i_measured_temp;
            r_a_stby <= i_standby_mode;
        end
    end

    hpd_integ u_integ (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_setpoint (r_setpoint),
        .i_a_vld    (r_a_vld),
        .i_a_meas   (r_a_meas),
        .i_a_stby   (r_a_stby),
        .i_c_adv    (c_adv),
        .o_b_adv    (b_adv),
        .o_b_vld    (b_vld),
        .o_b_item   (b_item)
    );

    hpd_sum #(
        .DUTY_MAX (DUTY_MAX)
    ) u_sum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_b_vld       (b_vld),
        .i_b_item      (b_item),
        .i_out_stall   (i_out_stall),
        .o_c_adv       (c_adv),
        .o_out_valid   (o_out_valid),
        .o_heater_duty (o_heater_duty)
    );

    // Checks
    `HPD_ASSERT_IMP(a_integ_range, b_vld,
        (b_item.integ <= IntegW'(ILimit)) && (b_item.integ >= -IntegW'(ILimit)),
        "integral out of clamp range")
    `HPD_ASSERT_IMP(a_duty_max, o_out_valid && (DUTY_MAX < 32768),
        32'(o_heater_duty) <= 32'(DUTY_MAX), "duty above limit")
    `HPD_ASSERT_IMP(a_stall_full, o_in_stall,
        r_a_vld && b_vld && o_out_valid && i_out_stall, "input stalled with free stage")

endmodule

// ----- tb/heater_pid_duty_top_test.sv -----
// ---------------------------------------------------------------------------
// heater_pid_duty_top_test
// Self-checking bench for the heater PID duty block: requests are pushed
// through the input channel under several idle/stall mixes and setpoints,
// a local PID model predicts every duty, and the monitor compares each
// output request against the oldest prediction.
// ---------------------------------------------------------------------------
module heater_pid_duty_top_test;

    localparam int MeasW    = hpd_pkg::MeasW;
    localparam int DutyW    = hpd_pkg::DutyW;
    localparam int AddrW    = hpd_pkg::AddrW;
    localparam int SpW      = hpd_pkg::SpW;
    localparam int DUTY_MAX = 24999;

    // Register indexes; index 1 is unmapped and must ignore writes
    localparam int RegSetpointIdx = int'(hpd_pkg::RegSetpoint);
    localparam int RegUnmappedIdx = 1;

    // Gains of the loop, sum formed in half units
    localparam int IntGain   = 125;
    localparam int PropHalf  = 1150;
    localparam int DerivHalf = 375;
    localparam int IntClamp  = 4000;

    localparam int StallLimit  = 2000;
    localparam int SettleTicks = 8;
    localparam int RandPerPhase = 212;

    typedef struct packed {
        logic signed [MeasW-1:0] temp;
        logic                    standby;
    } sample_t;

    // DUT connections
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               o_in_stall;
    logic [MeasW-1:0]   meas_drv = '0;
    logic               standby_drv = 1'b0;
    logic               o_out_valid;
    logic               out_stall = 1'b0;
    logic [DutyW-1:0]   o_heater_duty;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [AddrW-1:0]   paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Bench state
    sample_t            sample_queue[$];
    logic [DutyW-1:0]   duty_pending[$];
    sample_t            cur_sample;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 err_count = 0;
    int                 quiet_cycles = 0;

    // Loop model state
    logic [SpW-1:0]     sp_deg = '0;
    int                 integ_acc = 0;
    int                 last_err = 0;

    heater_pid_duty_top #(
        .DUTY_MAX(DUTY_MAX)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_measured_temp(meas_drv),
        .i_standby_mode (standby_drv),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_heater_duty  (o_heater_duty),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic int target_of(input logic standby);
        if (standby) begin
            return int'(sp_deg >> 1) * 16;
        end
        return int'(sp_deg) * 16;
    endfunction

    // One control tick of the PID loop: updates integral and last error
    function automatic logic [DutyW-1:0] next_duty(input sample_t s);
        int     meas;
        int     err;
        longint acc;
        longint sum2;
        longint duty;
        meas = s.temp;
        err  = target_of(s.standby) - meas;

        acc = longint'(integ_acc) + longint'(IntGain) * err;
        if (acc > IntClamp) begin
            acc = IntClamp;
        end else if (acc < -IntClamp) begin
            acc = -IntClamp;
        end
        integ_acc = int'(acc);

        sum2 = longint'(PropHalf) * err + 2 * longint'(integ_acc)
             + longint'(DerivHalf) * (longint'(last_err) - err);
        last_err = err;

        // negative sums give zero, otherwise halve toward zero and saturate
        duty = (sum2 < 0) ? 0 : sum2 / 2;
        if (duty > DUTY_MAX) begin
            duty = DUTY_MAX;
        end
        return duty[DutyW-1:0];
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        int      kind;
        int      m;
        s.standby = 1'($urandom_range(1));
        kind = $urandom_range(99);
        if (kind < 60) begin
            // hover around the target so the error stays small
            m = target_of(s.standby) + int'($urandom_range(48)) - 24;
            if (m > 16383) m = 16383;
            if (m < -16384) m = -16384;
            s.temp = m[MeasW-1:0];
        end else if (kind < 88) begin
            s.temp = MeasW'($urandom);
        end else begin
            case ($urandom_range(3))
                0: s.temp = 15'sh4000;
                1: s.temp = 15'sh3FFF;
                2: s.temp = '1;
                default: s.temp = '0;
            endcase
        end
        return s;
    endfunction

    task automatic add_sample(input int temp, input logic standby);
        sample_t s;
        s.temp    = temp[MeasW-1:0];
        s.standby = standby;
        sample_queue.push_back(s);
    endtask

    // Driver: presents queued requests, holds them while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                duty_pending.push_back(next_duty(cur_sample));
            end
            if (!in_valid || !o_in_stall) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_sample = sample_queue.pop_front();
                    meas_drv    <= cur_sample.temp;
                    standby_drv <= cur_sample.standby;
                    in_valid    <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output request, drives random stall
    always @(posedge i_clk) begin
        logic [DutyW-1:0] want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (duty_pending.size() == 0) begin
                    flag_error($sformatf("unexpected duty %0d", o_heater_duty));
                end else begin
                    want = duty_pending.pop_front();
                    if (o_heater_duty !== want) begin
                        flag_error($sformatf("duty %0d, want %0d", o_heater_duty, want));
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: only counts while work is outstanding
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (sample_queue.size() == 0 && !in_valid && duty_pending.size() == 0)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles + 1 >= StallLimit) begin
                    $display("watchdog: no progress for %0d cycles", StallLimit);
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    task automatic apb_write(input int idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == RegSetpointIdx) begin
            sp_deg = data[SpW-1:0];
        end
    endtask

    task automatic apb_read(input int idx, output logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= AddrW'(idx * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sample_queue.size() != 0 || in_valid || duty_pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleTicks) @(posedge i_clk);
    endtask

    // New setpoint between phases; also pokes the unmapped register
    task automatic set_setpoint(input logic [31:0] word);
        logic [31:0] rd;
        wait_idle();
        apb_write(RegSetpointIdx, word);
        apb_write(RegUnmappedIdx, $urandom);
        apb_read(RegSetpointIdx, rd);
        if (rd !== {{(32-SpW){1'b0}}, sp_deg}) begin
            flag_error($sformatf("setpoint readback %0h, want %0h", rd, sp_deg));
        end
    endtask

    // Stimulus sequence
    initial begin
        logic [31:0] sp_word[8];
        bit          sp_rand[8];
        int          idle_in[8];
        int          idle_out[8];
        sp_word  = '{32'h0000_0200, 32'hFFFF_FFFF, 32'h0, 32'h0000_FC00,
                     32'h0, 32'h0000_0001, 32'h0, 32'h0000_03FE};
        sp_rand  = '{0, 0, 1, 0, 1, 0, 1, 0};
        idle_in  = '{0, 83, 0, 33, 0, 83, 0, 33};
        idle_out = '{0, 0, 83, 33, 0, 0, 83, 33};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hot setpoint with junk in the upper bits: saturation both ways,
        // integral clamping, standby halving
        set_setpoint(32'hFFFF_F3FF);
        add_sample(16383, 1'b0);
        add_sample(16368, 1'b0);
        add_sample(-16384, 1'b0);
        add_sample(-16384, 1'b1);
        add_sample(16383, 1'b0);
        add_sample(16383, 1'b1);
        add_sample(16383, 1'b1);
        add_sample(8176, 1'b1);
        add_sample(8176, 1'b1);
        add_sample(16367, 1'b0);
        add_sample(16369, 1'b0);
        add_sample(0, 1'b0);

        // zero setpoint: standby and normal share the target
        set_setpoint(32'h0000_FC00);
        add_sample(0, 1'b0);
        add_sample(0, 1'b1);
        add_sample(16383, 1'b0);
        add_sample(-16384, 1'b1);
        add_sample(-16384, 1'b0);
        add_sample(-1, 1'b0);
        add_sample(1, 1'b1);
        add_sample(16383, 1'b1);
        add_sample(5, 1'b0);
        add_sample(-5, 1'b0);

        for (int p = 0; p < 8; p++) begin
            set_setpoint(sp_rand[p] ? $urandom : sp_word[p]);
            send_idle_pct  = idle_in[p];
            recv_stall_pct = idle_out[p];
            for (int n = 0; n < RandPerPhase; n++) begin
                sample_queue.push_back(rand_sample());
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (duty_pending.size() != 0) begin
            flag_error($sformatf("%0d duty requests never arrived", duty_pending.size()));
        end
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/hpd_pkg.sv
hdl/hpd_integ.sv
hdl/hpd_sum.sv
hdl/heater_pid_duty_top.sv
tb/heater_pid_duty_top_test.sv
